// File: rtl/dmaf_pkg.sv
// ============================================================================
// dmaf_pkg
// Shared types and constants for the Diameter message and AVP framer.
// ============================================================================
package dmaf_pkg;

    localparam int HEADER_BYTES     = 20;
    localparam int AVP_MIN_BYTES    = 8;
    localparam int VENDOR_HDR_BYTES = AVP_MIN_BYTES + 4;
    localparam int AVP_CODE_BYTES   = 4;
    localparam int AVP_FLAGS_POS    = 4;
    localparam int VENDOR_BIT       = 7;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_AVP     = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_SHORT_HEADER  = 2'd0,
        ERR_AVP_LENGTH    = 2'd1,
        ERR_AVP_TRUNCATED = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_AVPHDR  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_PAD     = 3'd3,
        PH_WAIT    = 3'd4
    } phase_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  code;
        logic [7:0]   flag_bits;
        logic [23:0]  length_value;
        logic [31:0]  first_id;
        logic [31:0]  hop_id;
        logic [31:0]  end_id;
        logic [7:0]   version;
        logic [7:0]   payload_byte;
        logic         vendor_present;
        logic         avp_done;
        err_t         error_code;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: rtl/dmaf_parser.sv
// ============================================================================
// dmaf_parser
// Per-byte parse state and result generation for one message byte per cycle while go is high.
// ============================================================================
module dmaf_parser
    import dmaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output push_t       push
);

    phase_t      phase_reg, phase_next;
    logic [23:0] bp_reg, bp_next;
    logic [23:0] total_reg, total_next;
    logic [31:0] code_reg, code_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] vendor_reg, vendor_next;
    logic [1:0]  pad_reg, pad_next;
    logic [7:0]  hdr_reg [0:HEADER_BYTES-2];
    logic [7:0]  hdr_next [0:HEADER_BYTES-2];

    logic [23:0] bp_inc;
    logic [23:0] paylen;
    logic        complete;
    logic        start_avp;
    logic        main_valid;
    logic        err_valid;
    result_t     main_res;
    result_t     err_res;

    assign bp_inc = bp_reg + 24'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        bp_next     = bp_reg;
        total_next  = total_reg;
        code_next   = code_reg;
        flags_next  = flags_reg;
        vendor_next = vendor_reg;
        pad_next    = pad_reg;
        hdr_next    = hdr_reg;
        paylen      = '0;
        complete    = 1'b0;
        start_avp   = 1'b0;
        main_valid  = 1'b0;
        err_valid   = 1'b0;
        main_res    = '0;
        err_res     = '0;
        err_res.kind = KIND_ERROR;

        if (go)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    for (int i = 0; i < HEADER_BYTES - 2; i++)
                    begin
                        hdr_next[i] = hdr_reg[i+1];
                    end
                    hdr_next[HEADER_BYTES-2] = data_byte;
                    if (bp_reg == 24'(HEADER_BYTES - 1))
                    begin
                        main_valid            = 1'b1;
                        main_res.kind         = KIND_HEADER;
                        main_res.version      = hdr_reg[0];
                        main_res.length_value = {hdr_reg[1], hdr_reg[2], hdr_reg[3]};
                        main_res.flag_bits    = hdr_reg[4];
                        main_res.code         = {8'd0, hdr_reg[5], hdr_reg[6], hdr_reg[7]};
                        main_res.first_id     = {hdr_reg[8], hdr_reg[9],
                                                 hdr_reg[10], hdr_reg[11]};
                        main_res.hop_id       = {hdr_reg[12], hdr_reg[13],
                                                 hdr_reg[14], hdr_reg[15]};
                        main_res.end_id       = {hdr_reg[16], hdr_reg[17],
                                                 hdr_reg[18], data_byte};
                        start_avp             = 1'b1;
                    end
                    else
                    begin
                        bp_next = bp_inc;
                        if (end_of_message)
                        begin
                            err_valid          = 1'b1;
                            err_res.error_code = ERR_SHORT_HEADER;
                        end
                    end
                end
                PH_AVPHDR:
                begin
                    if (bp_reg < 24'(AVP_CODE_BYTES))
                    begin
                        code_next = {code_reg[23:0], data_byte};
                    end
                    else if (bp_reg == 24'(AVP_FLAGS_POS))
                    begin
                        flags_next = data_byte;
                    end
                    else if (bp_reg < 24'(AVP_MIN_BYTES))
                    begin
                        total_next = {total_reg[15:0], data_byte};
                    end
                    else
                    begin
                        vendor_next = {vendor_reg[23:0], data_byte};
                    end
                    bp_next = bp_inc;
                    if (bp_inc == 24'(AVP_MIN_BYTES))
                    begin
                        if (total_next < (flags_next[VENDOR_BIT] ? 24'(VENDOR_HDR_BYTES)
                                                                 : 24'(AVP_MIN_BYTES)))
                        begin
                            err_valid          = 1'b1;
                            err_res.error_code = ERR_AVP_LENGTH;
                            phase_next         = PH_WAIT;
                        end
                        else if (!flags_next[VENDOR_BIT])
                        begin
                            complete = 1'b1;
                        end
                    end
                    else if (bp_inc >= 24'(VENDOR_HDR_BYTES))
                    begin
                        complete = 1'b1;
                    end
                    if (complete)
                    begin
                        paylen                  = total_next - bp_inc;
                        main_valid              = 1'b1;
                        main_res.kind           = KIND_AVP;
                        main_res.code           = code_next;
                        main_res.flag_bits      = flags_next;
                        main_res.length_value   = paylen;
                        main_res.first_id       = flags_next[VENDOR_BIT] ? vendor_next : 32'd0;
                        main_res.vendor_present = flags_next[VENDOR_BIT];
                        main_res.avp_done       = (paylen == 24'd0);
                        pad_next                = 2'd0 - total_next[1:0];
                        if (paylen != 24'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else if (pad_next != 2'd0)
                        begin
                            phase_next = PH_PAD;
                        end
                        else
                        begin
                            start_avp = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    bp_next               = bp_inc;
                    main_valid            = 1'b1;
                    main_res.kind         = KIND_PAYLOAD;
                    main_res.payload_byte = data_byte;
                    if (bp_inc >= total_reg)
                    begin
                        main_res.avp_done = 1'b1;
                        if (pad_reg != 2'd0)
                        begin
                            phase_next = PH_PAD;
                        end
                        else
                        begin
                            start_avp = 1'b1;
                        end
                    end
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0)
                    begin
                        start_avp = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (start_avp)
            begin
                phase_next  = PH_AVPHDR;
                bp_next     = '0;
                total_next  = '0;
                code_next   = '0;
                flags_next  = '0;
                vendor_next = '0;
                pad_next    = '0;
            end

            if (end_of_message)
            begin
                if ((phase_next == PH_AVPHDR && bp_next != 24'd0) ||
                    phase_next == PH_PAYLOAD)
                begin
                    err_valid          = 1'b1;
                    err_res.error_code = ERR_AVP_TRUNCATED;
                end
                phase_next = PH_HEADER;
                bp_next    = '0;
                pad_next   = '0;
            end
        end
    end

    always_comb
    begin
        push.count  = 2'({1'b0, main_valid} + {1'b0, err_valid});
        push.first  = main_valid ? main_res : err_res;
        push.second = err_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            bp_reg     <= '0;
            total_reg  <= '0;
            code_reg   <= '0;
            flags_reg  <= '0;
            vendor_reg <= '0;
            pad_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bp_reg     <= bp_next;
            total_reg  <= total_next;
            code_reg   <= code_next;
            flags_reg  <= flags_next;
            vendor_reg <= vendor_next;
            pad_reg    <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

endmodule

// File: rtl/dmaf_out_fifo.sv
// ============================================================================
// dmaf_out_fifo
// Small result buffer that takes up to two results per cycle and gives one while out_ready is high.
// ============================================================================
module dmaf_out_fifo
    import dmaf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t               buf_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign head      = buf_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            buf_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            buf_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// File: rtl/diameter_message_avp_framer.sv
// ============================================================================
// diameter_message_avp_framer
// Splits a byte stream of Diameter messages into header, AVP and payload items.
// ============================================================================
// An accepted byte is held in the input register and parsed once the result
// buffer has space. Throughput: one byte per cycle while the buffer has space;
// a byte may yield two results (an item followed by a truncation error).
// The four-entry result buffer and the input register set the input ready.
// Reset: rst_n clears all control state at once; no clearing pass is needed.
module diameter_message_avp_framer
    import dmaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] code,
    output logic [7:0]  flag_bits,
    output logic [23:0] length_value,
    output logic [31:0] first_id,
    output logic [31:0] hop_id,
    output logic [31:0] end_id,
    output logic [7:0]  version,
    output logic [7:0]  payload_byte,
    output logic        vendor_present,
    output logic        avp_done,
    output logic [1:0]  error_code
);

    logic       item_valid_reg;
    logic [7:0] byte_reg;
    logic       eom_reg;
    logic       space;
    logic       go;
    push_t      push;
    result_t    head;

    assign go       = item_valid_reg && space;
    assign in_ready = !item_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= data_byte;
            eom_reg  <= end_of_message;
        end
    end

    dmaf_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .data_byte      (byte_reg),
        .end_of_message (eom_reg),
        .push           (push)
    );

    dmaf_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind           = head.kind;
    assign code           = head.code;
    assign flag_bits      = head.flag_bits;
    assign length_value   = head.length_value;
    assign first_id       = head.first_id;
    assign hop_id         = head.hop_id;
    assign end_id         = head.end_id;
    assign version        = head.version;
    assign payload_byte   = head.payload_byte;
    assign vendor_present = head.vendor_present;
    assign avp_done       = head.avp_done;
    assign error_code     = head.error_code;

endmodule

// File: dv/tb_diameter_message_avp_framer.sv
// ============================================================================
// tb_diameter_message_avp_framer
// Streams Diameter messages into the framer, one byte per item, and checks
// every header, AVP, payload and error item against a predictor that tracks
// the parse state byte by byte, with random gaps and stalls on both sides.
// ============================================================================
module tb_diameter_message_avp_framer;
    import dmaf_pkg::*;

    localparam int ITEM_TARGET    = 1550;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_CAP     = 200;

    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;

    class framer_scoreboard;
        result_t     expected_items[$];
        int          errors = 0;
        phase_t      parse_phase = PH_HEADER;
        int          byte_pos = 0;
        logic [7:0]  hdr_bytes [HEADER_BYTES];
        int          avp_length = 0;
        logic [31:0] code_acc = '0;
        logic [7:0]  avp_flags = '0;
        logic [31:0] vendor_acc = '0;
        int          pad_left = 0;

        function int pending();
            return expected_items.size();
        endfunction

        function void start_avp();
            parse_phase = PH_AVPHDR;
            byte_pos = 0;
            avp_length = 0;
            code_acc = '0;
            avp_flags = '0;
            vendor_acc = '0;
            pad_left = 0;
        endfunction

        function void close_payload();
            if (pad_left != 0)
                parse_phase = PH_PAD;
            else
                start_avp();
        endfunction

        function void push_error(err_t err);
            result_t r;
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = err;
            expected_items.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic eom);
            result_t r;
            int      need;
            int      paylen;
            logic    complete;
            complete = 1'b0;
            case (parse_phase)
                PH_HEADER:
                begin
                    if (byte_pos >= HEADER_BYTES)
                        byte_pos = 0;
                    hdr_bytes[byte_pos] = b;
                    byte_pos++;
                    if (byte_pos == HEADER_BYTES)
                    begin
                        r = '0;
                        r.kind = KIND_HEADER;
                        r.version = hdr_bytes[0];
                        r.length_value = {hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
                        r.flag_bits = hdr_bytes[4];
                        r.code = {8'h00, hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
                        r.first_id = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
                        r.hop_id = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
                        r.end_id = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
                        expected_items.push_back(r);
                        start_avp();
                    end
                    else if (eom)
                    begin
                        push_error(ERR_SHORT_HEADER);
                    end
                end
                PH_AVPHDR:
                begin
                    if (byte_pos < AVP_CODE_BYTES)
                        code_acc = {code_acc[23:0], b};
                    else if (byte_pos == AVP_FLAGS_POS)
                        avp_flags = b;
                    else if (byte_pos < AVP_MIN_BYTES)
                        avp_length = ((avp_length << 8) | int'(b)) & 'hFFFFFF;
                    else
                        vendor_acc = {vendor_acc[23:0], b};
                    byte_pos++;
                    need = avp_flags[VENDOR_BIT] ? VENDOR_HDR_BYTES : AVP_MIN_BYTES;
                    if (byte_pos == AVP_MIN_BYTES)
                    begin
                        if (avp_length < need)
                        begin
                            push_error(ERR_AVP_LENGTH);
                            parse_phase = PH_WAIT;
                        end
                        else if (need == AVP_MIN_BYTES)
                        begin
                            complete = 1'b1;
                        end
                    end
                    else if (byte_pos >= VENDOR_HDR_BYTES)
                    begin
                        complete = 1'b1;
                    end
                    if (complete)
                    begin
                        paylen = avp_length - byte_pos;
                        r = '0;
                        r.kind = KIND_AVP;
                        r.code = code_acc;
                        r.flag_bits = avp_flags;
                        r.length_value = paylen[23:0];
                        r.vendor_present = avp_flags[VENDOR_BIT];
                        r.first_id = avp_flags[VENDOR_BIT] ? vendor_acc : 32'h0;
                        r.avp_done = (paylen == 0);
                        expected_items.push_back(r);
                        pad_left = (4 - (avp_length & 3)) & 3;
                        if (paylen != 0)
                            parse_phase = PH_PAYLOAD;
                        else
                            close_payload();
                    end
                end
                PH_PAYLOAD:
                begin
                    byte_pos = (byte_pos + 1) & 'hFFFFFF;
                    r = '0;
                    r.kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    if (byte_pos >= avp_length)
                    begin
                        r.avp_done = 1'b1;
                        close_payload();
                    end
                    expected_items.push_back(r);
                end
                PH_PAD:
                begin
                    pad_left = (pad_left - 1) & 3;
                    if (pad_left == 0)
                        start_avp();
                end
                default:
                begin
                end
            endcase
            if (eom)
            begin
                if ((parse_phase == PH_AVPHDR && byte_pos != 0) || parse_phase == PH_PAYLOAD)
                    push_error(ERR_AVP_TRUNCATED);
                parse_phase = PH_HEADER;
                byte_pos = 0;
                pad_left = 0;
            end
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] want_v);
            if (errors < REPORT_CAP)
                $display("mismatch on %s: got %h, expected %h", what, got_v, want_v);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_items.size() == 0)
            begin
                report("unexpected item, kind", 32'(got.kind), 32'h0);
            end
            else
            begin
                want = expected_items.pop_front();
                if (got.kind !== want.kind)
                    report("kind", 32'(got.kind), 32'(want.kind));
                if (got.code !== want.code)
                    report("code", got.code, want.code);
                if (got.flag_bits !== want.flag_bits)
                    report("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
                if (got.length_value !== want.length_value)
                    report("length_value", 32'(got.length_value), 32'(want.length_value));
                if (got.first_id !== want.first_id)
                    report("first_id", got.first_id, want.first_id);
                if (got.hop_id !== want.hop_id)
                    report("hop_id", got.hop_id, want.hop_id);
                if (got.end_id !== want.end_id)
                    report("end_id", got.end_id, want.end_id);
                if (got.version !== want.version)
                    report("version", 32'(got.version), 32'(want.version));
                if (got.payload_byte !== want.payload_byte)
                    report("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
                if (got.vendor_present !== want.vendor_present)
                    report("vendor_present", 32'(got.vendor_present), 32'(want.vendor_present));
                if (got.avp_done !== want.avp_done)
                    report("avp_done", 32'(got.avp_done), 32'(want.avp_done));
                if (got.error_code !== want.error_code)
                    report("error_code", 32'(got.error_code), 32'(want.error_code));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [31:0] code;
    logic [7:0]  flag_bits;
    logic [23:0] length_value;
    logic [31:0] first_id;
    logic [31:0] hop_id;
    logic [31:0] end_id;
    logic [7:0]  version;
    logic [7:0]  payload_byte;
    logic        vendor_present;
    logic        avp_done;
    logic [1:0]  error_code;

    framer_scoreboard sb = new();
    logic [7:0]       frame[$];
    int               bytes_sent = 0;
    int               quiet_cycles = 0;
    logic             no_idle = 1'b0;
    logic             long_hold = 1'b0;

    diameter_message_avp_framer u_top (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_len();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_bytes(logic [31:0] value, int count);
        for (int i = count - 1; i >= 0; i--)
            frame.push_back(value[8*i +: 8]);
    endfunction

    function automatic void put_header(int fill);
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            if (fill == FILL_ZERO)
                frame.push_back(8'h00);
            else if (fill == FILL_ONES)
                frame.push_back(8'hFF);
            else
                frame.push_back(8'($urandom));
        end
    endfunction

    function automatic void put_avp(logic [31:0] code_word, logic [7:0] avp_flags,
                                    logic [23:0] avp_len, logic [31:0] vendor);
        int hdr_len;
        hdr_len = avp_flags[VENDOR_BIT] ? VENDOR_HDR_BYTES : AVP_MIN_BYTES;
        put_bytes(code_word, 4);
        frame.push_back(avp_flags);
        put_bytes({8'h00, avp_len}, 3);
        if (avp_flags[VENDOR_BIT])
            put_bytes(vendor, 4);
        if (avp_len <= 24'd64)
        begin
            for (int i = hdr_len; i < int'(avp_len); i++)
                frame.push_back(8'($urandom));
            repeat ((4 - int'(avp_len[1:0])) & 3)
                frame.push_back(8'($urandom));
        end
        else
        begin
            repeat (3)
                frame.push_back(8'($urandom));
        end
    endfunction

    function automatic void trim_frame(int keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endfunction

    function automatic logic [23:0] random_avp_len(logic vendor_bit);
        int base;
        int pick;
        base = vendor_bit ? VENDOR_HDR_BYTES : AVP_MIN_BYTES;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            return 24'(base + $urandom_range(0, 12));
        if (pick < 95)
            return 24'(base + $urandom_range(13, 48));
        return 24'($urandom_range(65, 24'hFFFFFF));
    endfunction

    task automatic send_byte(logic [7:0] b, logic eom);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        data_byte = b;
        end_of_message = eom;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic random_message();
        int          shape;
        int          need;
        logic [7:0]  fl;
        shape = $urandom_range(0, 99);
        if (shape < 7)
        begin
            repeat ($urandom_range(1, 19))
                frame.push_back(8'($urandom));
        end
        else if (shape < 11)
        begin
            repeat ($urandom_range(20, 60))
                frame.push_back(8'($urandom));
        end
        else
        begin
            put_header(FILL_RANDOM);
            repeat ($urandom_range(0, 3))
            begin
                fl = 8'($urandom);
                put_avp($urandom, fl, random_avp_len(fl[VENDOR_BIT]), $urandom);
            end
            if (shape < 20)
            begin
                fl = 8'($urandom);
                need = fl[VENDOR_BIT] ? VENDOR_HDR_BYTES : AVP_MIN_BYTES;
                put_avp($urandom, fl, 24'($urandom_range(0, need - 1)), $urandom);
            end
            else if (shape < 34 && frame.size() > HEADER_BYTES + 1)
            begin
                trim_frame($urandom_range(HEADER_BYTES + 1, frame.size() - 1));
            end
        end
        send_frame();
    endtask

    initial
    begin
        int msg_index;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        end_of_message = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        frame.push_back(8'hFF);
        send_frame();
        repeat (19) frame.push_back(8'h00);
        send_frame();
        put_header(FILL_ONES);
        send_frame();
        put_header(FILL_ZERO);
        put_avp(32'h0, 8'h00, 24'd8, 32'h0);
        put_avp(32'hFFFF_FFFF, 8'hFF, 24'd13, 32'hFFFF_FFFF);
        put_avp(32'h1, 8'h7F, 24'd11, 32'h0);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'h5, 8'h00, 24'd7, 32'h0);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'h6, 8'h80, 24'd11, 32'h1);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'h7, 8'h40, 24'd0, 32'h0);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'h8, 8'h00, 24'd16, 32'h0);
        trim_frame(HEADER_BYTES + 3);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'h9, 8'h00, 24'd20, 32'h0);
        trim_frame(HEADER_BYTES + AVP_MIN_BYTES + 2);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'hA, 8'h00, 24'd9, 32'h0);
        trim_frame(HEADER_BYTES + AVP_MIN_BYTES + 2);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'hB, 8'h80, 24'd12, 32'h1234_5678);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'hC, 8'h00, 24'd16, 32'h0);
        trim_frame(HEADER_BYTES + AVP_MIN_BYTES);
        send_frame();
        put_header(FILL_RANDOM);
        put_avp(32'hFFFF_FFFF, 8'hFF, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_frame();

        msg_index = 0;
        while (bytes_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 11) == 0)
                no_idle = !no_idle;
            if (msg_index == 6 || msg_index == 22)
                long_hold = 1'b1;
            if (msg_index % 10 == 9)
                drain_results();
            random_message();
            msg_index++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int ready_run;
        int ready_gap;
        ready_run = 0;
        ready_gap = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                ready_gap = HOLD_CYCLES;
            end
            if (ready_gap == 0 && ready_run == 0)
            begin
                ready_gap = idle_len();
                ready_run = $urandom_range(1, 32);
            end
            if (ready_gap > 0)
            begin
                out_ready = 1'b0;
                ready_gap--;
            end
            else
            begin
                out_ready = 1'b1;
                ready_run--;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(data_byte, end_of_message);
            if (out_valid && out_ready)
            begin
                got.kind = kind_t'(kind);
                got.code = code;
                got.flag_bits = flag_bits;
                got.length_value = length_value;
                got.first_id = first_id;
                got.hop_id = hop_id;
                got.end_id = end_id;
                got.version = version;
                got.payload_byte = payload_byte;
                got.vendor_present = vendor_present;
                got.avp_done = avp_done;
                got.error_code = err_t'(error_code);
                sb.check_result(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
